FILE: hw/rtl/dltq_pkg.sv
// dltq_pkg: request and response types and codes of the delta-list timer queue
// no dependencies; imported by the top level and its checker
`default_nettype none

package dltq_pkg;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SCHEDULE = 2'd1,
    REQ_CANCEL   = 2'd2,
    REQ_NOP      = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DUP_SCHED  = 2'd1,
    ST_NOT_QUEUED = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  timer_id;
    logic [15:0] delay;
  } req_t;

  typedef struct packed {
    logic       rang;
    logic [3:0] rang_id;
    status_e    status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dltq_ram.sv
// dltq_ram: one-write, one-read array with registered read data
// no dependencies; holds the delta and link columns of the timer list
`default_nettype none

module dltq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/delta_list_timer_queue.sv
// delta_list_timer_queue: timer list ordered by expiry, deltas kept per entry
// depends on dltq_pkg (types, codes) and dltq_ram (delta and link columns)
//
// Usage:
//   A request (tick, schedule, cancel or no-op) is taken on a rising edge
//   where start is high and busy is low. Exactly one response follows per
//   request: done_o is high for one cycle with rsp_o carrying rang, rang_id
//   and status. The receiver has no way to hold a response back.
//   A rejected request, a no-op or a tick on an empty list is answered
//   straight from idle. A tick counts the head delta down and rings the
//   head id at zero. A schedule walks the list in the compare state, then
//   inserts before the first larger delta or appends at the tail (at once
//   on an empty list). A cancel walks for the predecessor of the id unless
//   it is the head, unlinks it and adds its delta to the successor; a tail
//   or lone entry is removed without that add.
//   The walk reads one entry per cycle through the single read port of the
//   delta/link arrays and one shared add/subtract unit does every delta
//   compare and delta update. A request answered straight from idle never
//   raises busy; for the others busy is high from the cycle after
//   acceptance until the response cycle.
//   Reset empties the list at once (per-id queued bits are flip-flops);
//   the arrays themselves are not cleared and their data is only used for queued ids.
`default_nettype none

module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned DELAY_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int unsigned IW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TICK = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_INS1 = 4'd3;
  localparam logic [3:0] S_INS2 = 4'd4;
  localparam logic [3:0] S_APP  = 4'd5;
  localparam logic [3:0] S_CW   = 4'd6;
  localparam logic [3:0] S_CR   = 4'd7;
  localparam logic [3:0] S_CADD = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [IW-1:0]         head_q, head_d;
  logic [IW-1:0]         tail_q, tail_d;
  logic [CW-1:0]         count_q, count_d;
  logic [NUM_TIMERS-1:0] queued_q, queued_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  logic [IW-1:0]         cur_q, cur_d;
  logic [IW-1:0]         prev_q, prev_d;
  logic                  prev_vld_q, prev_vld_d;
  logic [IW-1:0]         id_q, id_d;
  logic [CW-1:0]         walk_q, walk_d;
  logic [DELAY_BITS-1:0] rem_q, rem_d;
  logic [DELAY_BITS-1:0] dcur_q, dcur_d;

  // array ports
  logic                  dly_we, lnk_we;
  logic [IW-1:0]         dly_waddr, lnk_waddr;
  logic [DELAY_BITS-1:0] dly_wdata, dly_rd;
  logic [IW-1:0]         lnk_wdata, lnk_rd;

  // shared add/subtract unit
  logic [DELAY_BITS-1:0] alu_a, alu_b;
  logic                  alu_sub;
  logic [DELAY_BITS:0]   alu_res;
  logic                  alu_borrow;
  logic [DELAY_BITS-1:0] alu_sum;

  logic [IW+3:0]           id_ext;
  logic [IW-1:0]           id_ix;
  logic                    id_ok;
  logic [DELAY_BITS+15:0]  dly_ext;
  logic [DELAY_BITS-1:0]   d_in;
  logic [IW+3:0]           head_ext;

  assign id_ext   = {{IW{1'b0}}, req_i.timer_id};
  assign id_ix    = id_ext[IW-1:0];
  assign id_ok    = id_ext < (IW + 4)'(NUM_TIMERS);
  assign dly_ext  = {{DELAY_BITS{1'b0}}, req_i.delay};
  assign d_in     = dly_ext[DELAY_BITS-1:0];
  assign head_ext = {4'b0000, head_q};

  assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_borrow = alu_res[DELAY_BITS];
  assign alu_sum    = alu_res[DELAY_BITS-1:0];

  always_comb begin
    alu_a   = rem_q;
    alu_b   = dly_rd;
    alu_sub = 1'b1;
    unique case (state_q)
      S_TICK: begin
        alu_a = dly_rd;
        alu_b = {{(DELAY_BITS-1){1'b0}}, |dly_rd};
      end
      S_INS1: begin
        alu_a = dcur_q;
        alu_b = rem_q;
      end
      S_CADD: begin
        alu_a   = dly_rd;
        alu_b   = dcur_q;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = rem_q;
        alu_b = dly_rd;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    queued_d   = queued_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    id_d       = id_q;
    walk_d     = walk_q;
    rem_d      = rem_q;
    dcur_d     = dcur_q;
    dly_we     = 1'b0;
    dly_waddr  = id_q;
    dly_wdata  = rem_q;
    lnk_we     = 1'b0;
    lnk_waddr  = prev_q;
    lnk_wdata  = id_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          id_d       = id_ix;
          rem_d      = d_in;
          prev_vld_d = 1'b0;
          walk_d     = '0;
          unique case (req_i.req_type)
            REQ_TICK: begin
              if (count_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
              end else begin
                cur_d   = head_q;
                state_d = S_TICK;
              end
            end
            REQ_SCHEDULE: begin
              if (!id_ok || queued_q[id_ix]) begin
                done_d = 1'b1;
                rsp_d  = '{rang: 1'b0, rang_id: 4'd0, status: ST_DUP_SCHED};
              end else begin
                queued_d[id_ix] = 1'b1;
                if (count_q == '0) begin
                  state_d = S_APP;
                end else begin
                  cur_d   = head_q;
                  state_d = S_CMP;
                end
              end
            end
            REQ_CANCEL: begin
              if (!id_ok || !queued_q[id_ix] || count_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{rang: 1'b0, rang_id: 4'd0, status: ST_NOT_QUEUED};
              end else begin
                queued_d[id_ix] = 1'b0;
                if (id_ix == head_q) begin
                  cur_d   = id_ix;
                  state_d = S_CR;
                end else begin
                  cur_d   = head_q;
                  state_d = S_CW;
                end
              end
            end
            REQ_NOP: begin
              done_d = 1'b1;
              rsp_d  = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
            end
          endcase
        end
      end

      S_TICK: begin
        dly_we    = 1'b1;
        dly_waddr = head_q;
        dly_wdata = alu_sum;
        done_d    = 1'b1;
        state_d   = S_IDLE;
        if (alu_sum == '0) begin
          queued_d[head_q] = 1'b0;
          count_d          = count_q - CW'(1);
          if (count_q > CW'(1)) begin
            head_d = lnk_rd;
          end
          rsp_d = '{rang: 1'b1, rang_id: head_ext[3:0], status: ST_OK};
        end else begin
          rsp_d = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
        end
      end

      // schedule walk: rem holds the delay left after the entries passed
      S_CMP: begin
        if (alu_borrow) begin
          dcur_d  = dly_rd;
          state_d = S_INS1;
        end else begin
          rem_d      = alu_sum;
          prev_d     = cur_q;
          prev_vld_d = 1'b1;
          if ((walk_q + CW'(1)) == count_q) begin
            state_d = S_APP;
          end else begin
            walk_d = walk_q + CW'(1);
            cur_d  = lnk_rd;
          end
        end
      end

      S_INS1: begin
        dly_we    = 1'b1;
        dly_waddr = cur_q;
        dly_wdata = alu_sum;
        lnk_we    = 1'b1;
        lnk_waddr = id_q;
        lnk_wdata = cur_q;
        state_d   = S_INS2;
      end

      S_INS2, S_APP: begin
        dly_we    = 1'b1;
        dly_waddr = id_q;
        dly_wdata = rem_q;
        if (prev_vld_q) begin
          lnk_we    = 1'b1;
          lnk_waddr = prev_q;
          lnk_wdata = id_q;
        end else begin
          head_d = id_q;
        end
        if (state_q == S_APP) begin
          tail_d = id_q;
        end
        count_d = count_q + CW'(1);
        done_d  = 1'b1;
        rsp_d   = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
        state_d = S_IDLE;
      end

      // cancel walk: look for the predecessor of the id
      S_CW: begin
        if (lnk_rd == id_q) begin
          if (id_q == tail_q) begin
            tail_d  = cur_q;
            count_d = count_q - CW'(1);
            done_d  = 1'b1;
            rsp_d   = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
            state_d = S_IDLE;
          end else begin
            prev_d     = cur_q;
            prev_vld_d = 1'b1;
            cur_d      = id_q;
            state_d    = S_CR;
          end
        end else if ((walk_q + CW'(2)) == count_q) begin
          done_d  = 1'b1;
          rsp_d   = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
          state_d = S_IDLE;
        end else begin
          walk_d = walk_q + CW'(1);
          cur_d  = lnk_rd;
        end
      end

      S_CR: begin
        if (!prev_vld_q && count_q == CW'(1)) begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          rsp_d   = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
          state_d = S_IDLE;
        end else begin
          if (prev_vld_q) begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_q;
            lnk_wdata = lnk_rd;
          end
          dcur_d  = dly_rd;
          cur_d   = lnk_rd;
          state_d = S_CADD;
        end
      end

      // successor takes over the removed delta
      S_CADD: begin
        dly_we    = 1'b1;
        dly_waddr = cur_q;
        dly_wdata = alu_sum;
        if (!prev_vld_q) begin
          head_d = cur_q;
        end
        count_d = count_q - CW'(1);
        done_d  = 1'b1;
        rsp_d   = '{rang: 1'b0, rang_id: 4'd0, status: ST_OK};
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      queued_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      queued_q <= queued_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q      <= rsp_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_vld_q <= prev_vld_d;
    id_q       <= id_d;
    walk_q     <= walk_d;
    rem_q      <= rem_d;
    dcur_q     <= dcur_d;
  end

  // read address is the next-state cur_d, so the registered data is ready in the state that uses it
  dltq_ram #(
    .Width (DELAY_BITS),
    .Depth (NUM_TIMERS)
  ) u_delta (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (cur_d),
    .rdata_o (dly_rd)
  );

  dltq_ram #(
    .Width (IW),
    .Depth (NUM_TIMERS)
  ) u_link (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (cur_d),
    .rdata_o (lnk_rd)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dltq_checker.sv
// dltq_checker: port-level properties of the timer queue, bound to the top level
// depends on dltq_pkg and delta_list_timer_queue
`default_nettype none

module dltq_checker
  import dltq_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire rsp_t rsp_o
);

  // a response only shows once the block is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response while busy");

  // every accepted request either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request dropped");

  // leaving busy always delivers the response
  a_busy_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy ended without a response");

  a_quiet_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.rang) |-> (rsp_o.rang_id == 4'd0))
    else $error("rang_id set without a ring");

  a_ring_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.rang) |-> (rsp_o.status == ST_OK))
    else $error("ring with error status");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
